// ===== sv/rpa_pkg.sv =====
`timescale 1ns / 1ps
package rpa_pkg;

  localparam int TRIG_ITERATIONS = 18;
  localparam int SQRT_STEPS      = 32;
  localparam int QUO_BITS        = 31;
  localparam int Q_FRAC          = 30;
  localparam int DIV_LAT         = QUO_BITS + 1;
  localparam int CORDIC_LAT      = TRIG_ITERATIONS + 1;
  localparam int TRIG_DLY        = SQRT_STEPS + DIV_LAT - CORDIC_LAT;

  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef logic signed [31:0] s32_t;
  typedef logic signed [32:0] s33_t;
  typedef logic signed [33:0] s34_t;
  typedef logic signed [39:0] s40_t;

  typedef struct packed {
    s32_t center_x;
    s32_t center_y;
    s32_t center_z;
    s32_t axis_x;
    s32_t axis_y;
    s32_t axis_z;
    s32_t point_x;
    s32_t point_y;
    s32_t point_z;
    logic signed [19:0] angle;
  } in_item_t;

  typedef struct packed {
    s32_t rot_x;
    s32_t rot_y;
    s32_t rot_z;
    logic degenerate_axis;
  } out_item_t;

  // point data that rides along with the axis math
  typedef struct packed {
    s32_t [2:0] c;
    s32_t [2:0] p;
    s33_t [2:0] d;
    logic       degen;
  } pt_t;

  typedef struct packed {
    logic [2:0][31:0] uabs;
    logic [2:0]       usign;
    pt_t              pt;
  } axis_side_t;

  typedef struct packed {
    logic [2:0] usign;
    pt_t        pt;
  } div_side_t;

  // round(a * b / 2^30), half up
  function automatic s40_t mulq(input logic signed [35:0] a, input logic signed [35:0] b);
    logic signed [71:0] prod;
    logic signed [71:0] rnd;
    prod = a * b;
    rnd  = prod + 72'sd536870912;
    return rnd[69:30];
  endfunction

endpackage

// ===== sv/rpa_if.sv =====
`timescale 1ns / 1ps
interface rpa_in_if;
  logic                valid;
  logic                ready;
  rpa_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rpa_out_if;
  logic                valid;
  logic                ready;
  rpa_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rpa_prep.sv =====
`timescale 1ns / 1ps
module rpa_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  rpa_pkg::in_item_t    in_data,
  output logic                 out_valid,
  output logic [63:0]          out_l2,
  output rpa_pkg::axis_side_t  out_side,
  output rpa_pkg::s32_t        out_th,
  output logic                 out_neg
);

  // stage 1
  logic             v1_r;
  logic [2:0][31:0] uabs1_r;
  logic [2:0]       usign1_r;
  logic [31:0]      mxor1_r;
  rpa_pkg::pt_t     pt1_r;
  logic signed [35:0] th1_r;

  logic [2:0][31:0] uabs1_nxt;
  logic [2:0]       usign1_nxt;
  logic [31:0]      mxor1_nxt;
  rpa_pkg::pt_t     pt1_nxt;
  logic signed [35:0] th1_nxt;

  always_comb begin
    logic [2:0][31:0] u;
    u = {in_data.axis_z, in_data.axis_y, in_data.axis_x};
    pt1_nxt.c = {in_data.center_z, in_data.center_y, in_data.center_x};
    pt1_nxt.p = {in_data.point_z, in_data.point_y, in_data.point_x};
    for (int i = 0; i < 3; i++) begin
      usign1_nxt[i] = u[i][31];
      uabs1_nxt[i]  = u[i][31] ? (32'd0 - u[i]) : u[i];
      pt1_nxt.d[i]  = $signed({pt1_nxt.p[i][31], pt1_nxt.p[i]})
                    - $signed({pt1_nxt.c[i][31], pt1_nxt.c[i]});
    end
    mxor1_nxt    = uabs1_nxt[0] | uabs1_nxt[1] | uabs1_nxt[2];
    pt1_nxt.degen = (mxor1_nxt == 32'd0);
    th1_nxt      = $signed({{2{in_data.angle[19]}}, in_data.angle, 14'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uabs1_r  <= uabs1_nxt;
      usign1_r <= usign1_nxt;
      mxor1_r  <= mxor1_nxt;
      pt1_r    <= pt1_nxt;
      th1_r    <= th1_nxt;
    end
  end

  // stage 2: normalize the axis, reduce the angle into [-pi, pi]
  logic             v2_r;
  logic [2:0][31:0] uabs2_r;
  logic [2:0]       usign2_r;
  rpa_pkg::pt_t     pt2_r;
  logic signed [35:0] th2_r;

  logic [2:0][31:0] uabs2_nxt;
  logic signed [35:0] th2_nxt;

  always_comb begin
    logic [4:0] msb;
    logic [4:0] sh;
    msb = '0;
    for (int b = 0; b < 32; b++) begin
      if (mxor1_r[b]) msb = 5'(b);
    end
    sh = (msb >= 5'd30) ? 5'd0 : 5'(5'd30 - msb);
    for (int i = 0; i < 3; i++) begin
      uabs2_nxt[i] = uabs1_r[i] << sh;
    end
    if (th1_r > rpa_pkg::Q30_PI) begin
      th2_nxt = th1_r - rpa_pkg::Q30_TWO_PI;
    end else if (th1_r < -rpa_pkg::Q30_PI) begin
      th2_nxt = th1_r + rpa_pkg::Q30_TWO_PI;
    end else begin
      th2_nxt = th1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uabs2_r  <= uabs2_nxt;
      usign2_r <= usign1_r;
      pt2_r    <= pt1_r;
      th2_r    <= th2_nxt;
    end
  end

  // stage 3: squares, fold the angle into [-pi/2, pi/2]
  logic             v3_r;
  logic [2:0][63:0] sq3_r;
  logic [2:0][31:0] uabs3_r;
  logic [2:0]       usign3_r;
  rpa_pkg::pt_t     pt3_r;
  rpa_pkg::s32_t    th3_r;
  logic             neg3_r;

  logic [2:0][63:0] sq3_nxt;
  rpa_pkg::s32_t    th3_nxt;
  logic             neg3_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq3_nxt[i] = 64'(uabs2_r[i]) * 64'(uabs2_r[i]);
    end
    if (th2_r > rpa_pkg::Q30_HALF_PI) begin
      th3_nxt  = 32'(th2_r - rpa_pkg::Q30_PI);
      neg3_nxt = 1'b1;
    end else if (th2_r < -rpa_pkg::Q30_HALF_PI) begin
      th3_nxt  = 32'(th2_r + rpa_pkg::Q30_PI);
      neg3_nxt = 1'b1;
    end else begin
      th3_nxt  = 32'(th2_r);
      neg3_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq3_r    <= sq3_nxt;
      uabs3_r  <= uabs2_r;
      usign3_r <= usign2_r;
      pt3_r    <= pt2_r;
      th3_r    <= th3_nxt;
      neg3_r   <= neg3_nxt;
    end
  end

  // stage 4: squared length
  logic                v4_r;
  logic [63:0]         l2_r;
  rpa_pkg::axis_side_t side4_r;
  rpa_pkg::s32_t       th4_r;
  logic                neg4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2_r          <= sq3_r[0] + sq3_r[1] + sq3_r[2];
      side4_r.uabs  <= uabs3_r;
      side4_r.usign <= usign3_r;
      side4_r.pt    <= pt3_r;
      th4_r         <= th3_r;
      neg4_r        <= neg3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_l2    = l2_r;
  assign out_side  = side4_r;
  assign out_th    = th4_r;
  assign out_neg   = neg4_r;

endmodule

// ===== sv/rpa_cordic.sv =====
`timescale 1ns / 1ps
module rpa_cordic (
  input  logic          clk,
  input  logic          en,
  input  rpa_pkg::s32_t in_th,
  input  logic          in_neg,
  output rpa_pkg::s34_t out_sn,
  output rpa_pkg::s34_t out_cs
);

  localparam int N = rpa_pkg::TRIG_ITERATIONS;

  rpa_pkg::s34_t x_r [N];
  rpa_pkg::s34_t y_r [N];
  rpa_pkg::s34_t t_r [N];
  logic          neg_r [N];

  genvar i;
  for (i = 0; i < N; i++) begin : g_iter
    rpa_pkg::s34_t x_in, y_in, t_in;
    rpa_pkg::s34_t x_nxt, y_nxt, t_nxt;
    logic          neg_in;
    rpa_pkg::s34_t ang;

    if (i == 0) begin : g_first
      assign x_in   = rpa_pkg::CORDIC_GAIN;
      assign y_in   = '0;
      assign t_in   = 34'(in_th);
      assign neg_in = in_neg;
    end else begin : g_next
      assign x_in   = x_r[i-1];
      assign y_in   = y_r[i-1];
      assign t_in   = t_r[i-1];
      assign neg_in = neg_r[i-1];
    end

    assign ang = $signed({2'b00, rpa_pkg::ATAN_Q30[i]});

    always_comb begin
      if (t_in >= 0) begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        t_nxt = t_in - ang;
      end else begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        t_nxt = t_in + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]   <= x_nxt;
        y_r[i]   <= y_nxt;
        t_r[i]   <= t_nxt;
        neg_r[i] <= neg_in;
      end
    end
  end

  // undo the fold by pi
  rpa_pkg::s34_t sn_r, cs_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r <= neg_r[N-1] ? -y_r[N-1] : y_r[N-1];
      cs_r <= neg_r[N-1] ? -x_r[N-1] : x_r[N-1];
    end
  end

  assign out_sn = sn_r;
  assign out_cs = cs_r;

endmodule

// ===== sv/rpa_isqrt.sv =====
`timescale 1ns / 1ps
module rpa_isqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [63:0]          in_n,
  input  rpa_pkg::axis_side_t  in_side,
  output logic                 out_valid,
  output logic [31:0]          out_len,
  output rpa_pkg::axis_side_t  out_side
);

  localparam int N = rpa_pkg::SQRT_STEPS;

  logic                v_r    [N];
  logic [63:0]         n_r    [N];
  logic [63:0]         res_r  [N];
  rpa_pkg::axis_side_t side_r [N];

  genvar i;
  for (i = 0; i < N; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic                v_in;
    logic [63:0]         n_in, res_in, trial;
    logic [63:0]         n_nxt, res_nxt;
    rpa_pkg::axis_side_t side_in;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign n_in    = in_n;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign n_in    = n_r[i-1];
      assign res_in  = res_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (n_in >= trial) begin
        n_nxt   = n_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i]    <= n_nxt;
        res_r[i]  <= res_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_len   = res_r[N-1][31:0];
  assign out_side  = side_r[N-1];

  // a normalized axis has a squared length of at least 2^60
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_side.pt.degen |-> out_len[31:30] != 2'b00)
    else $error("axis length below normalized range");

endmodule

// ===== sv/rpa_div.sv =====
`timescale 1ns / 1ps
module rpa_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [31:0]          in_len,
  input  rpa_pkg::axis_side_t  in_side,
  output logic                 out_valid,
  output logic [2:0][31:0]     out_k,
  output rpa_pkg::div_side_t   out_side
);

  localparam int N  = rpa_pkg::QUO_BITS;
  localparam int RW = 32 + rpa_pkg::Q_FRAC;

  logic                    v_r    [N];
  logic [2:0][RW-1:0]      rem_r  [N];
  logic [2:0][N-1:0]       q_r    [N];
  logic [31:0]             len_r  [N];
  rpa_pkg::div_side_t      side_r [N];

  genvar j;
  for (j = 0; j < N; j++) begin : g_bit
    localparam int B = N - 1 - j;
    logic               v_in;
    logic [2:0][RW-1:0] rem_in, rem_nxt;
    logic [2:0][N-1:0]  q_in, q_nxt;
    logic [31:0]        len_in;
    rpa_pkg::div_side_t side_in;

    if (j == 0) begin : g_first
      assign v_in          = in_valid;
      assign len_in        = in_len;
      assign q_in          = '0;
      assign side_in.usign = in_side.usign;
      assign side_in.pt    = in_side.pt;
      for (genvar c = 0; c < 3; c++) begin : g_num
        assign rem_in[c] = {in_side.uabs[c], {rpa_pkg::Q_FRAC{1'b0}}};
      end
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign len_in  = len_r[j-1];
      assign q_in    = q_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign side_in = side_r[j-1];
    end

    always_comb begin
      logic [RW:0] dvs;
      logic [RW:0] ext;
      dvs = (RW + 1)'(len_in) << B;
      for (int c = 0; c < 3; c++) begin
        ext = {1'b0, rem_in[c]};
        q_nxt[c] = q_in[c];
        if (ext >= dvs) begin
          rem_nxt[c]  = RW'(ext - dvs);
          q_nxt[c][B] = 1'b1;
        end else begin
          rem_nxt[c]  = rem_in[c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
        len_r[j]  <= len_in;
        side_r[j] <= side_in;
      end
    end
  end

  // apply the axis sign
  logic               vk_r;
  logic [2:0][31:0]   k_r;
  rpa_pkg::div_side_t sidek_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vk_r <= 1'b0;
    end else if (en) begin
      vk_r <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        k_r[c] <= side_r[N-1].usign[c] ? (32'd0 - 32'(q_r[N-1][c])) : 32'(q_r[N-1][c]);
      end
      sidek_r <= side_r[N-1];
    end
  end

  assign out_valid = vk_r;
  assign out_k     = k_r;
  assign out_side  = sidek_r;

  // unit axis components never exceed one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_side.pt.degen |->
      $signed(out_k[0]) <= 32'sd1073741824 && $signed(out_k[0]) >= -32'sd1073741824 &&
      $signed(out_k[1]) <= 32'sd1073741824 && $signed(out_k[1]) >= -32'sd1073741824 &&
      $signed(out_k[2]) <= 32'sd1073741824 && $signed(out_k[2]) >= -32'sd1073741824)
    else $error("unit axis component out of range");

endmodule

// ===== sv/rpa_math.sv =====
`timescale 1ns / 1ps
module rpa_math (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0][31:0]   in_k,
  input  rpa_pkg::pt_t       in_pt,
  input  rpa_pkg::s34_t      in_sn,
  input  rpa_pkg::s34_t      in_cs,
  output logic               out_valid,
  output rpa_pkg::out_item_t out_data
);

  // X1: k_i * d_j, cos * d_i
  logic          v1_r;
  rpa_pkg::s40_t kd1_r  [3][3];
  rpa_pkg::s40_t csd1_r [3];
  rpa_pkg::s34_t om1_r, sn1_r;
  logic [2:0][31:0] k1_r;
  rpa_pkg::pt_t  pt1_r;

  rpa_pkg::s40_t kd1_nxt  [3][3];
  rpa_pkg::s40_t csd1_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kd1_nxt[i][j] = rpa_pkg::mulq(36'($signed(in_k[i])), 36'($signed(in_pt.d[j])));
      end
      csd1_nxt[i] = rpa_pkg::mulq(36'(in_cs), 36'($signed(in_pt.d[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kd1_r  <= kd1_nxt;
      csd1_r <= csd1_nxt;
      om1_r  <= rpa_pkg::ONE_Q30 - in_cs;
      sn1_r  <= in_sn;
      k1_r   <= in_k;
      pt1_r  <= in_pt;
    end
  end

  // X2: dot product and cross product
  logic          v2_r;
  rpa_pkg::s40_t dot2_r;
  rpa_pkg::s40_t cr2_r  [3];
  rpa_pkg::s40_t csd2_r [3];
  rpa_pkg::s34_t om2_r, sn2_r;
  logic [2:0][31:0] k2_r;
  rpa_pkg::pt_t  pt2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot2_r   <= kd1_r[0][0] + kd1_r[1][1] + kd1_r[2][2];
      cr2_r[0] <= kd1_r[1][2] - kd1_r[2][1];
      cr2_r[1] <= kd1_r[2][0] - kd1_r[0][2];
      cr2_r[2] <= kd1_r[0][1] - kd1_r[1][0];
      csd2_r   <= csd1_r;
      om2_r    <= om1_r;
      sn2_r    <= sn1_r;
      k2_r     <= k1_r;
      pt2_r    <= pt1_r;
    end
  end

  // X3: k_i * dot, sin * cross_i
  logic          v3_r;
  rpa_pkg::s40_t kdot3_r [3];
  rpa_pkg::s40_t sncr3_r [3];
  rpa_pkg::s40_t csd3_r  [3];
  rpa_pkg::s34_t om3_r;
  rpa_pkg::pt_t  pt3_r;

  rpa_pkg::s40_t kdot3_nxt [3];
  rpa_pkg::s40_t sncr3_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kdot3_nxt[i] = rpa_pkg::mulq(36'($signed(k2_r[i])), 36'(dot2_r));
      sncr3_nxt[i] = rpa_pkg::mulq(36'(sn2_r), 36'(cr2_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kdot3_r <= kdot3_nxt;
      sncr3_r <= sncr3_nxt;
      csd3_r  <= csd2_r;
      om3_r   <= om2_r;
      pt3_r   <= pt2_r;
    end
  end

  // X4: (1 - cos) * k_i * dot
  logic          v4_r;
  rpa_pkg::s40_t omk4_r  [3];
  rpa_pkg::s40_t sncr4_r [3];
  rpa_pkg::s40_t csd4_r  [3];
  rpa_pkg::pt_t  pt4_r;

  rpa_pkg::s40_t omk4_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      omk4_nxt[i] = rpa_pkg::mulq(36'(om3_r), 36'(kdot3_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      omk4_r  <= omk4_nxt;
      sncr4_r <= sncr3_r;
      csd4_r  <= csd3_r;
      pt4_r   <= pt3_r;
    end
  end

  // X5: final sum, saturate, pass the point through on a zero axis
  logic               v5_r;
  rpa_pkg::out_item_t out5_r;
  rpa_pkg::out_item_t out5_nxt;

  always_comb begin
    rpa_pkg::s40_t  r;
    rpa_pkg::s32_t  sat [3];
    for (int i = 0; i < 3; i++) begin
      r = 40'($signed(pt4_r.c[i])) + omk4_r[i] + csd4_r[i] + sncr4_r[i];
      if (r > 40'sd2147483647) begin
        sat[i] = 32'sh7fffffff;
      end else if (r < -40'sd2147483648) begin
        sat[i] = 32'sh80000000;
      end else begin
        sat[i] = 32'(r);
      end
      if (pt4_r.degen) sat[i] = pt4_r.p[i];
    end
    out5_nxt.rot_x           = sat[0];
    out5_nxt.rot_y           = sat[1];
    out5_nxt.rot_z           = sat[2];
    out5_nxt.degenerate_axis = pt4_r.degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out5_r <= out5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out5_r;

endmodule

// ===== sv/rotate_point_about_axis_top.sv =====
`timescale 1ns / 1ps
// Rotates a point by an angle about an axis through a center point.
// in_ch carries one request per point: center, axis direction (any length),
// point, all signed Q16.16, and the angle as signed Q3.16 radians.
// out_ch returns the rotated point, saturated to 32 bits, and a flag that
// is set when the axis is all zero (the point then comes back unchanged).
// The datapath has 4 prep stages, 32 square-root stages, 31 divider stages
// plus a sign stage, and 5 multiply and sum stages. Sine and cosine come
// from a CORDIC pipeline of 18 iteration stages plus a sign stage; it runs
// beside the square root and is delayed to meet the divider output.
// Throughput: one request per cycle when not stalled (fully pipelined).
// Stall: the whole pipeline holds while out_ch.valid is high and
// out_ch.ready is low; in_ch.ready drops in that case and every stage keeps
// its contents until the output is taken. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears every stage valid bit; requests in
// flight are discarded.
module rotate_point_about_axis_top (
  input  logic  clk,
  input  logic  rst_n,
  rpa_in_if.sink    in_ch,
  rpa_out_if.source out_ch
);

  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic                prep_v;
  logic [63:0]         prep_l2;
  rpa_pkg::axis_side_t prep_side;
  rpa_pkg::s32_t       prep_th;
  logic                prep_neg;

  rpa_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_data   (in_ch.data),
    .out_valid (prep_v),
    .out_l2    (prep_l2),
    .out_side  (prep_side),
    .out_th    (prep_th),
    .out_neg   (prep_neg)
  );

  rpa_pkg::s34_t trig_sn, trig_cs;

  rpa_cordic u_cordic (
    .clk    (clk),
    .en     (en),
    .in_th  (prep_th),
    .in_neg (prep_neg),
    .out_sn (trig_sn),
    .out_cs (trig_cs)
  );

  logic                sq_v;
  logic [31:0]         sq_len;
  rpa_pkg::axis_side_t sq_side;

  rpa_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_v),
    .in_n      (prep_l2),
    .in_side   (prep_side),
    .out_valid (sq_v),
    .out_len   (sq_len),
    .out_side  (sq_side)
  );

  logic               dv_v;
  logic [2:0][31:0]   dv_k;
  rpa_pkg::div_side_t dv_side;

  rpa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .in_len    (sq_len),
    .in_side   (sq_side),
    .out_valid (dv_v),
    .out_k     (dv_k),
    .out_side  (dv_side)
  );

  // align sine and cosine with the divider output
  rpa_pkg::s34_t sn_d_r [rpa_pkg::TRIG_DLY];
  rpa_pkg::s34_t cs_d_r [rpa_pkg::TRIG_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      sn_d_r[0] <= trig_sn;
      cs_d_r[0] <= trig_cs;
      for (int i = 1; i < rpa_pkg::TRIG_DLY; i++) begin
        sn_d_r[i] <= sn_d_r[i-1];
        cs_d_r[i] <= cs_d_r[i-1];
      end
    end
  end

  rpa_math u_math (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_v),
    .in_k      (dv_k),
    .in_pt     (dv_side.pt),
    .in_sn     (sn_d_r[rpa_pkg::TRIG_DLY-1]),
    .in_cs     (cs_d_r[rpa_pkg::TRIG_DLY-1]),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

  assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid survived reset");

endmodule

// ===== verif/tb_rotate_point_about_axis_top.sv =====
`timescale 1ns / 1ps
module tb_rotate_point_about_axis_top;

  localparam int LATENCY = 73;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;

  localparam longint ATAN_TAB [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0};

  typedef struct {
    rpa_pkg::in_item_t  req;
    bit                 known;
    rpa_pkg::out_item_t res;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  rpa_pkg::out_item_t rot_queue[$];
  vec_t      vectors[$];

  rpa_in_if  in_ch();
  rpa_out_if out_ch();

  rotate_point_about_axis_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  initial begin
    #40ms;
    $display("tb_rotate_point_about_axis_top: errors");
    $finish;
  end

  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  // round(a*b / 2^30) half up, exact in 128 bits
  function automatic longint round_q30(longint a, longint b);
    logic signed [127:0] prod;
    prod = 128'(a) * 128'(b) + 128'sd536870912;
    return longint'(prod >>> 30);
  endfunction

  function automatic longint root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void sin_cos(logic signed [19:0] ang, output longint sn,
                                  output longint cs);
    longint th, x, y, t;
    bit flip;
    th = longint'(ang) * 16384;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    while (th > PI_Q30) th -= TWO_PI_Q30;
    while (th < -PI_Q30) th += TWO_PI_Q30;
    if (th > HALF_PI_Q30) begin
      th -= PI_Q30;
      flip = 1;
    end else if (th < -HALF_PI_Q30) begin
      th += PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < rpa_pkg::TRIG_ITERATIONS; i++) begin
      if (th >= 0) begin
        t = x - floor_shr(y, i); y = y + floor_shr(x, i); x = t; th -= ATAN_TAB[i];
      end else begin
        t = x + floor_shr(y, i); y = y - floor_shr(x, i); x = t; th += ATAN_TAB[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sn = y;
    cs = x;
  endfunction

  function automatic rpa_pkg::out_item_t rotate_point(rpa_pkg::in_item_t q);
    rpa_pkg::out_item_t o;
    longint c[3], u[3], d[3], k[3], cr[3], r;
    longint sn, cs, om, dotp, len;
    longint unsigned mx, l2, a;
    int sh;
    c = '{q.center_x, q.center_y, q.center_z};
    u = '{q.axis_x, q.axis_y, q.axis_z};
    d = '{longint'(q.point_x) - c[0], longint'(q.point_y) - c[1],
          longint'(q.point_z) - c[2]};
    if (u[0] == 0 && u[1] == 0 && u[2] == 0) begin
      o.rot_x = q.point_x;
      o.rot_y = q.point_y;
      o.rot_z = q.point_z;
      o.degenerate_axis = 1'b1;
      return o;
    end
    mx = 0;
    l2 = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      a = longint'(u[i] < 0 ? -u[i] : u[i]);
      if (a > mx) mx = a;
    end
    while ((mx << sh) < (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      u[i] = u[i] <<< sh;
      l2 += longint'(u[i] * u[i]);
    end
    len = root64(l2);
    for (int i = 0; i < 3; i++) k[i] = (u[i] * (64'sd1 << 30)) / len;
    sin_cos(q.angle, sn, cs);
    om = (64'sd1 << 30) - cs;
    dotp = round_q30(k[0], d[0]) + round_q30(k[1], d[1]) + round_q30(k[2], d[2]);
    cr[0] = round_q30(k[1], d[2]) - round_q30(k[2], d[1]);
    cr[1] = round_q30(k[2], d[0]) - round_q30(k[0], d[2]);
    cr[2] = round_q30(k[0], d[1]) - round_q30(k[1], d[0]);
    for (int i = 0; i < 3; i++) begin
      r = c[i] + round_q30(om, round_q30(k[i], dotp)) + round_q30(cs, d[i])
          + round_q30(sn, cr[i]);
      if (i == 0) o.rot_x = 32'(clamp32(r));
      else if (i == 1) o.rot_y = 32'(clamp32(r));
      else o.rot_z = 32'(clamp32(r));
    end
    o.degenerate_axis = 1'b0;
    return o;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'sh80000);
      3: return 32'($urandom_range(0, 7)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic rpa_pkg::in_item_t rand_request();
    rpa_pkg::in_item_t q;
    q.center_x = rand_coord(); q.center_y = rand_coord(); q.center_z = rand_coord();
    q.axis_x = rand_coord(); q.axis_y = rand_coord(); q.axis_z = rand_coord();
    q.point_x = rand_coord(); q.point_y = rand_coord(); q.point_z = rand_coord();
    if ($urandom_range(0, 19) == 0) begin
      q.axis_x = 0; q.axis_y = 0; q.axis_z = 0;
    end
    q.angle = 20'($urandom);
    return q;
  endfunction

  function automatic vec_t mk(rpa_pkg::in_item_t q);
    vec_t v;
    v.req = q;
    v.known = 0;
    v.res = '0;
    return v;
  endfunction

  function automatic rpa_pkg::in_item_t req_of(logic [31:0] cx, logic [31:0] ax,
                                               logic [31:0] ay, logic [31:0] az,
                                               logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz, logic [19:0] ang);
    rpa_pkg::in_item_t q;
    q.center_x = cx; q.center_y = 0; q.center_z = 0;
    q.axis_x = ax; q.axis_y = ay; q.axis_z = az;
    q.point_x = px; q.point_y = py; q.point_z = pz;
    q.angle = ang;
    return q;
  endfunction

  // drop valid only when idling, so back-to-back requests keep it high
  task automatic send(rpa_pkg::in_item_t q);
    in_ch.valid <= 1'b1;
    in_ch.data <= q;
    rot_queue.push_back(rotate_point(q));
    do @(posedge clk); while (!in_ch.ready);
    if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (send_idle > 0 && $urandom_range(0, 99) < send_idle);
    end
  endtask

  // receiver: stall at random, check every accepted result
  always @(posedge clk) begin
    rpa_pkg::out_item_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (rot_queue.size() == 0) begin
          $error("result with nothing pending: %h", out_ch.data);
          errors++;
        end else begin
          want = rot_queue.pop_front();
          if (out_ch.data.rot_x !== want.rot_x) begin
            $error("rot_x expected %h got %h", want.rot_x, out_ch.data.rot_x); errors++;
          end
          if (out_ch.data.rot_y !== want.rot_y) begin
            $error("rot_y expected %h got %h", want.rot_y, out_ch.data.rot_y); errors++;
          end
          if (out_ch.data.rot_z !== want.rot_z) begin
            $error("rot_z expected %h got %h", want.rot_z, out_ch.data.rot_z); errors++;
          end
          if (out_ch.data.degenerate_axis !== want.degenerate_axis) begin
            $error("degenerate_axis expected %b got %b", want.degenerate_axis,
                   out_ch.data.degenerate_axis);
            errors++;
          end
        end
      end
    end
    out_ch.ready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
  end

  initial begin
    vec_t v;
    rpa_pkg::in_item_t q;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero axis passes the point through, extremes included
    v = mk(req_of(32'h8000_0000, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 20'h7ffff));
    v.known = 1;
    v.res = '{32'h7fff_ffff, 32'h8000_0000, 32'h1, 1'b1};
    vectors.push_back(v);
    // angle zero about z: point stays put
    v = mk(req_of(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 20'h0));
    vectors.push_back(v);
    vectors.push_back(mk(req_of(0, 0, 0, 32'h7fff_ffff, 32'h0001_0000, 0, 0, 20'h1921f)));
    vectors.push_back(mk(req_of(0, 32'h8000_0000, 0, 0, 0, 32'h0001_0000, 0, 20'h3243f)));
    vectors.push_back(mk(req_of(32'h7fff_ffff, 1, 1, 1, 32'h8000_0000, 32'h7fff_ffff,
                                32'h8000_0000, 20'h80000)));
    vectors.push_back(mk(req_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h7fff_ffff, 20'h7ffff)));
    vectors.push_back(mk(req_of(0, 32'hffff_ffff, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                                0, 20'hcdbc1)));
    vectors.push_back(mk(req_of(32'hffff_ffff, 1, 0, 32'hffff_ffff, 32'hffff_ffff,
                                32'hffff_ffff, 32'hffff_ffff, 20'hfffff)));
    vectors.push_back(mk(req_of(32'h0001_0000, 32'h0003_0000, 32'h0004_0000, 0,
                                32'h0005_0000, 32'h0002_0000, 32'h8000_0000, 20'h6487e)));
    foreach (vectors[i]) begin
      if (vectors[i].known && rotate_point(vectors[i].req) !== vectors[i].res) begin
        $error("table row %0d disagrees with predictor", i);
        errors++;
      end
      send(vectors[i].req);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? 75 : 0;
      recv_stall = (ph == 2 || ph == 3) ? 75 : 0;
      if (ph == 3) begin
        send_idle = 8;
        recv_stall = 8;
      end
      for (int n = 0; n < 410; n++) begin
        q = rand_request();
        send(q);
      end
      // hold off until the pipeline drains
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (rot_queue.size() != 0);
    end

    send_idle = 0;
    recv_stall = 0;
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && rot_queue.size() == 0) begin
      $display("tb_rotate_point_about_axis_top: clean");
    end else begin
      $display("tb_rotate_point_about_axis_top: errors");
    end
    $finish;
  end
endmodule
